[design/pci_pkg.sv]
// ----------------------------------------------------------------------------
// PID controller package
// Shared widths, configuration register indexes, queue item and clamp helper.
// ----------------------------------------------------------------------------
`default_nettype none

package pci_pkg;

    localparam int DATA_WIDTH     = 16;
    localparam int GAIN_FRAC_BITS = 8;

    localparam int GAIN_W  = 16;
    localparam int ACC_W   = 32;
    localparam int LIM_W   = 31;
    localparam int ERR_W   = DATA_WIDTH + 1;   // e
    localparam int D1_W    = ERR_W + 1;        // e - e1
    localparam int D2_W    = ERR_W + 2;        // e - 2e1 + e2
    localparam int SUM_W   = GAIN_W + 1 + ACC_W - GAIN_FRAC_BITS + 2;
    localparam int TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT   = 3'd5;

    localparam logic MODE_INCREMENTAL = 1'b0;
    localparam logic MODE_POSITIONAL  = 1'b1;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic              loop_mode;
        logic [LIM_W-1:0]  integral_limit;
        logic [LIM_W-1:0]  output_limit;
    } t_cfg;

    // terms waiting for the multipliers; a clear command carries all zeros
    typedef struct packed {
        logic signed [D1_W-1:0]  term_p;
        logic signed [ACC_W-1:0] term_i;
        logic signed [D2_W-1:0]  term_d;
    } t_item;

    function automatic logic signed [ACC_W-1:0] clamp_mag(
        input logic signed [ACC_W-1:0] v,
        input logic [LIM_W-1:0]        lim
    );
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        logic signed [ACC_W-1:0] r;
        hi = $signed({1'b0, lim});
        lo = -hi;
        r  = v;
        if (lim != '0) begin
            if (v > hi) begin
                r = hi;
            end else if (v < lo) begin
                r = lo;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[design/pid_controller_pos_inc_top.sv]
// ----------------------------------------------------------------------------
// PID controller, positional and incremental forms - top level
// Path: input beat to queue, then product, sum and drive registers to the output beat.
// Throughput: one beat per cycle unless the queue is full; integral adds no stall.
// Stalls: a 4-entry operand queue plus a 3-stage datapath absorb output backpressure.
// Reset: synchronous active low; clears history, integral, registers, queue, valids.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_controller_pos_inc_top
    import pci_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [LIM_W-1:0]     i_cfg_data,
    // sample stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [TDATA_W-1:0]   s_axis_tdata,  // setpoint, measured
    input  wire logic                 s_axis_tuser,  // cmd
    // drive stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [ACC_W-1:0]          m_axis_tdata   // drive
);

    t_cfg  r_cfg;
    t_item f_item, q_item;
    logic  f_push, q_ready, q_valid, b_pop;
    logic signed [ACC_W-1:0] b_drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GAIN_P:         r_cfg.gain_p         <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:         r_cfg.gain_i         <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:         r_cfg.gain_d         <= i_cfg_data[GAIN_W-1:0];
                CFG_LOOP_MODE:      r_cfg.loop_mode      <= i_cfg_data[0];
                CFG_INTEGRAL_LIMIT: r_cfg.integral_limit <= i_cfg_data;
                CFG_OUTPUT_LIMIT:   r_cfg.output_limit   <= i_cfg_data;
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    pci_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_cmd      (s_axis_tuser),
        .i_setpoint ($signed(s_axis_tdata[DATA_WIDTH-1:0])),
        .i_measured ($signed(s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH])),
        .i_q_ready  (q_ready),
        .o_push     (f_push),
        .o_item     (f_item)
    );

    pci_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_wdata (f_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (b_pop),
        .o_rdata (q_item)
    );

    pci_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_pop   (b_pop),
        .o_valid (m_axis_tvalid),
        .o_drive (b_drive),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = b_drive;

endmodule

`default_nettype wire

[design/pci_front.sv]
// ----------------------------------------------------------------------------
// PID front end
// Takes samples, forms the error terms, keeps error history and integral,
// and pushes the three gain operands into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pci_front
    import pci_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_cfg                         i_cfg,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic                         i_cmd,
    input  wire logic signed [DATA_WIDTH-1:0] i_setpoint,
    input  wire logic signed [DATA_WIDTH-1:0] i_measured,
    input  wire logic                         i_q_ready,
    output logic                              o_push,
    output t_item                             o_item
);

    logic signed [ERR_W-1:0] r_e1, r_e2, n_e1, n_e2;
    logic signed [ACC_W-1:0] r_integ, n_integ;

    logic signed [ERR_W-1:0] err;
    logic signed [D1_W-1:0]  d1;
    logic signed [D2_W-1:0]  d2;
    logic signed [ACC_W:0]   isum_raw;
    logic signed [ACC_W-1:0] isum_sat;
    logic signed [ACC_W-1:0] isum;

    localparam logic signed [ACC_W:0] I_MAX = $signed({2'b00, {(ACC_W-1){1'b1}}});
    localparam logic signed [ACC_W:0] I_MIN = $signed({2'b11, {(ACC_W-1){1'b0}}});

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;

    always_comb begin
        err      = ERR_W'(i_setpoint) - ERR_W'(i_measured);
        d1       = D1_W'(err) - D1_W'(r_e1);
        d2       = D2_W'(err) - (D2_W'(r_e1) <<< 1) + D2_W'(r_e2);
        isum_raw = (ACC_W+1)'(r_integ) + (ACC_W+1)'(err);
        if (isum_raw > I_MAX) begin
            isum_sat = I_MAX[ACC_W-1:0];
        end else if (isum_raw < I_MIN) begin
            isum_sat = I_MIN[ACC_W-1:0];
        end else begin
            isum_sat = isum_raw[ACC_W-1:0];
        end
        isum = clamp_mag(isum_sat, i_cfg.integral_limit);

        n_e1    = r_e1;
        n_e2    = r_e2;
        n_integ = r_integ;
        if (i_cmd) begin
            o_item  = '0;
            n_e1    = '0;
            n_e2    = '0;
            n_integ = '0;
        end else begin
            n_e2 = r_e1;
            n_e1 = err;
            if (i_cfg.loop_mode == MODE_POSITIONAL) begin
                o_item.term_p = D1_W'(err);
                o_item.term_i = isum;
                o_item.term_d = D2_W'(d1);
                n_integ       = isum;
            end else begin
                o_item.term_p = d1;
                o_item.term_i = ACC_W'(err);
                o_item.term_d = d2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1    <= '0;
            r_e2    <= '0;
            r_integ <= '0;
        end else if (o_push) begin
            r_e1    <= n_e1;
            r_e2    <= n_e2;
            r_integ <= n_integ;
        end
    end

endmodule

`default_nettype wire

[design/pci_queue.sv]
// ----------------------------------------------------------------------------
// PID operand queue
// Short first-in first-out buffer between the front end and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module pci_queue
    import pci_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_wdata,
    output logic       o_ready,
    output logic       o_valid,
    input  wire logic  i_pop,
    output t_item      o_rdata
);

    t_item                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wptr, r_rptr;
    logic [QUEUE_AW:0]    r_count;
    logic                 pop;

    localparam logic [QUEUE_AW:0] FULL = (QUEUE_AW+1)'(QUEUE_DEPTH);

    assign o_ready = (r_count != FULL);
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rptr];
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

[design/pci_back.sv]
// ----------------------------------------------------------------------------
// PID datapath
// Three gain multiplies, scaled sum, then saturation and output clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module pci_back
    import pci_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_valid,
    input  wire t_item i_item,
    output logic       o_pop,
    output logic       o_valid,
    output logic signed [ACC_W-1:0] o_drive,
    input  wire logic  i_ready
);

    localparam logic signed [SUM_W-1:0] S_MAX = SUM_W'($signed({2'b00, {(ACC_W-1){1'b1}}}));
    localparam logic signed [SUM_W-1:0] S_MIN = SUM_W'($signed({2'b11, {(ACC_W-1){1'b0}}}));

    logic                             r_v1, r_v2, r_vo;
    logic signed [GAIN_W+D1_W:0]      r_pp;
    logic signed [GAIN_W+ACC_W:0]     r_pi;
    logic signed [GAIN_W+D2_W:0]      r_pd;
    logic signed [SUM_W-1:0]          r_sum, n_sum;
    logic signed [ACC_W-1:0]          r_drive, n_drive;
    logic signed [ACC_W-1:0]          sat;
    logic                             rdy_o, rdy_2, rdy_1;

    assign rdy_o = !r_vo || i_ready;
    assign rdy_2 = !r_v2 || rdy_o;
    assign rdy_1 = !r_v1 || rdy_2;
    assign o_pop = i_valid && rdy_1;

    always_comb begin
        // product >>> frac is floor division by the gain scale
        n_sum = SUM_W'(r_pp >>> GAIN_FRAC_BITS) + SUM_W'(r_pi >>> GAIN_FRAC_BITS)
              + SUM_W'(r_pd >>> GAIN_FRAC_BITS);
        if (r_sum > S_MAX) begin
            sat = S_MAX[ACC_W-1:0];
        end else if (r_sum < S_MIN) begin
            sat = S_MIN[ACC_W-1:0];
        end else begin
            sat = r_sum[ACC_W-1:0];
        end
        n_drive = clamp_mag(sat, i_cfg.output_limit);
    end

    always_ff @(posedge i_clk) begin
        if (rdy_1) begin
            r_pp <= $signed({1'b0, i_cfg.gain_p}) * i_item.term_p;
            r_pi <= $signed({1'b0, i_cfg.gain_i}) * i_item.term_i;
            r_pd <= $signed({1'b0, i_cfg.gain_d}) * i_item.term_d;
        end
        if (rdy_2) begin
            r_sum <= n_sum;
        end
        if (rdy_o) begin
            r_drive <= n_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy_1) begin
                r_v1 <= i_valid;
            end
            if (rdy_2) begin
                r_v2 <= r_v1;
            end
            if (rdy_o) begin
                r_vo <= r_v2;
            end
        end
    end

    assign o_valid = r_vo;
    assign o_drive = r_drive;

endmodule

`default_nettype wire

[design/pci_checker.sv]
// ----------------------------------------------------------------------------
// PID controller port checker
// Watches the top level's ports: reset state, output hold, output clamp and
// a known drive value on every valid beat.
// ----------------------------------------------------------------------------
`default_nettype none

module pci_checker
    import pci_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_cfg_we,
    input wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input wire logic [LIM_W-1:0]     i_cfg_data,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic [TDATA_W-1:0]   s_axis_tdata,
    input wire logic                 s_axis_tuser,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [ACC_W-1:0]     m_axis_tdata
);

    logic [LIM_W-1:0]        r_olim;
    logic signed [ACC_W-1:0] olim_hi;

    // shadow of the output limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_olim <= '0;
        end else if (i_cfg_we && i_cfg_idx == CFG_OUTPUT_LIMIT) begin
            r_olim <= i_cfg_data;
        end
    end

    assign olim_hi = $signed({1'b0, r_olim});

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready && !m_axis_tvalid)
        else $error("ports not idle after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled drive beat changed");

    a_out_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_olim != '0 |->
            $signed(m_axis_tdata) <= olim_hi && $signed(m_axis_tdata) >= -olim_hi)
        else $error("drive outside output limit");

    a_drive_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !$isunknown(m_axis_tdata))
        else $error("drive beat unknown");

endmodule

bind pid_controller_pos_inc_top pci_checker u_pci_checker (.*);

`default_nettype wire

[tb/pid_drive_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PID drive checker
// Watches the register port and both streams, keeps its own copy of the
// controller state, predicts the drive for every sample beat and compares it
// with the drive beats in order.
// ----------------------------------------------------------------------------
module pid_drive_checker
    import pci_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [LIM_W-1:0]     i_cfg_data,
    input  wire logic                 s_axis_tvalid,
    input  wire logic                 s_axis_tready,
    input  wire logic [TDATA_W-1:0]   s_axis_tdata,  // setpoint, measured
    input  wire logic                 s_axis_tuser,  // cmd
    input  wire logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    input  wire logic [ACC_W-1:0]     m_axis_tdata,  // drive
    output int                        o_pending,
    output int                        o_fail_count,
    output int                        o_drive_count
);

    t_cfg                    regs;
    logic signed [ERR_W-1:0] err_last;
    logic signed [ERR_W-1:0] err_prior;
    logic signed [ACC_W-1:0] integ_acc;
    logic signed [ACC_W-1:0] drive_q[$];

    initial begin
        o_pending     = 0;
        o_fail_count  = 0;
        o_drive_count = 0;
    end

    // gain is unsigned Q8.8; >>> on a signed longint floors
    function automatic longint gain_term(input logic [GAIN_W-1:0] gain, input longint term);
        longint prod;
        prod = longint'(gain) * term;
        return prod >>> GAIN_FRAC_BITS;
    endfunction

    function automatic longint sat_word(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end else if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint limit_mag(input longint v, input longint lim);
        if (lim > 0) begin
            if (v > lim) begin
                return lim;
            end else if (v < -lim) begin
                return -lim;
            end
        end
        return v;
    endfunction

    function automatic logic signed [ACC_W-1:0] next_drive(
        input logic                         clr,
        input logic signed [DATA_WIDTH-1:0] setpoint,
        input logic signed [DATA_WIDTH-1:0] measured
    );
        longint e;
        longint e1;
        longint e2;
        longint isum;
        longint acc;
        if (clr) begin
            err_last  = '0;
            err_prior = '0;
            integ_acc = '0;
            return '0;
        end
        e  = longint'(setpoint) - longint'(measured);
        e1 = longint'(err_last);
        e2 = longint'(err_prior);
        if (regs.loop_mode == MODE_POSITIONAL) begin
            // saturate first, then the optional magnitude clamp
            isum = limit_mag(sat_word(longint'(integ_acc) + e), longint'(regs.integral_limit));
            integ_acc = isum[ACC_W-1:0];
            acc = gain_term(regs.gain_p, e) + gain_term(regs.gain_i, isum)
                + gain_term(regs.gain_d, e - e1);
        end else begin
            acc = gain_term(regs.gain_p, e - e1) + gain_term(regs.gain_i, e)
                + gain_term(regs.gain_d, e - 2 * e1 + e2);
        end
        err_prior = err_last;
        err_last  = e[ERR_W-1:0];
        acc = limit_mag(sat_word(acc), longint'(regs.output_limit));
        return acc[ACC_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        logic signed [ACC_W-1:0] want;
        if (!i_rst_n) begin
            regs      = '0;
            err_last  = '0;
            err_prior = '0;
            integ_acc = '0;
            drive_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GAIN_P:         regs.gain_p = i_cfg_data[GAIN_W-1:0];
                    CFG_GAIN_I:         regs.gain_i = i_cfg_data[GAIN_W-1:0];
                    CFG_GAIN_D:         regs.gain_d = i_cfg_data[GAIN_W-1:0];
                    CFG_LOOP_MODE:      regs.loop_mode = i_cfg_data[0];
                    CFG_INTEGRAL_LIMIT: regs.integral_limit = i_cfg_data;
                    CFG_OUTPUT_LIMIT:   regs.output_limit = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                drive_q.push_back(next_drive(s_axis_tuser,
                                             s_axis_tdata[DATA_WIDTH-1:0],
                                             s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (drive_q.size() == 0) begin
                    $error("drive: expected nothing, got %0d", $signed(m_axis_tdata));
                    o_fail_count++;
                end else begin
                    want = drive_q.pop_front();
                    if (m_axis_tdata !== want) begin
                        $error("drive: expected %0d, got %0d", want, $signed(m_axis_tdata));
                        o_fail_count++;
                    end
                    o_drive_count++;
                end
            end
        end
        o_pending = drive_q.size();
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PID controller testbench
// Directed samples at the field extremes in both loop forms, random register
// settings with random samples and clears, a long output hold-off, and two
// integral wind-up runs that push the drive into saturation. Drive beats are
// checked in pid_drive_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import pci_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WINDUP_SAMPLES  = 140;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_SAMPLES   = 30;

    localparam logic signed [DATA_WIDTH-1:0] DATA_MAX = 16'sh7FFF;
    localparam logic signed [DATA_WIDTH-1:0] DATA_MIN = 16'sh8000;
    localparam logic CMD_STEP  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [LIM_W-1:0]     i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [ACC_W-1:0]     m_axis_tdata;

    int pending;
    int fail_count;
    int drive_count;
    int idle_cycles = 0;
    int burst_left  = 0;
    int n_samples   = 0;
    int n_clears    = 0;
    int n_settings  = 0;
    bit no_gaps      = 1'b0;
    bit hold_off_req = 1'b0;

    pid_controller_pos_inc_top dut (.*);

    pid_drive_checker chk (
        .*,
        .o_pending    (pending),
        .o_fail_count (fail_count),
        .o_drive_count(drive_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // output side: changing stall styles, plus one long hold-off on request
    initial begin
        int style;
        int span;
        int tick;
        style = 0;
        span  = 0;
        tick  = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
            end
            if (span == 0) begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(16, 96);
            end
            span--;
            tick++;
            case (style)
                0:       m_axis_tready = 1'b1;
                1:       m_axis_tready = 1'($urandom_range(0, 1));
                2:       m_axis_tready = ($urandom_range(0, 7) != 0);
                default: m_axis_tready = ((tick % 4) != 3);
            endcase
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIM_W-1:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic load_settings(
        input logic [GAIN_W-1:0] kp,
        input logic [GAIN_W-1:0] ki,
        input logic [GAIN_W-1:0] kd,
        input logic              mode,
        input logic [LIM_W-1:0]  ilim,
        input logic [LIM_W-1:0]  olim
    );
        write_reg(CFG_GAIN_P, LIM_W'(kp));
        write_reg(CFG_GAIN_I, LIM_W'(ki));
        write_reg(CFG_GAIN_D, LIM_W'(kd));
        write_reg(CFG_LOOP_MODE, LIM_W'(mode));
        write_reg(CFG_INTEGRAL_LIMIT, ilim);
        write_reg(CFG_OUTPUT_LIMIT, olim);
        n_settings++;
    endtask

    // register writes only once the pipe is empty
    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_sample(
        input logic                         clr,
        input logic signed [DATA_WIDTH-1:0] setpoint,
        input logic signed [DATA_WIDTH-1:0] measured
    );
        int gap;
        if (!no_gaps) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0) begin
                    gap = $urandom_range(1, 12);
                    s_axis_tvalid = 1'b0;
                    s_axis_tdata  = TDATA_W'($urandom);
                    repeat (gap) @(negedge i_clk);
                end
            end
            burst_left--;
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = clr;
        s_axis_tdata  = TDATA_W'({measured, setpoint});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        n_samples++;
        if (clr == CMD_CLEAR) begin
            n_clears++;
        end
    endtask

    function automatic logic signed [DATA_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return DATA_MAX;
            1:       return DATA_MIN;
            2:       return DATA_WIDTH'(int'($urandom_range(0, 64)) - 32);
            default: return DATA_WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return GAIN_W'(1 << GAIN_FRAC_BITS);
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic [LIM_W-1:0] pick_limit();
        case ($urandom_range(0, 6))
            0, 1:    return '0;
            2:       return LIM_W'(1);
            3:       return '1;
            4:       return LIM_W'($urandom_range(1, 200000));
            5:       return LIM_W'($urandom_range(1, 20000000));
            default: return LIM_W'($urandom);
        endcase
    endfunction

    task automatic send_random();
        send_sample(($urandom_range(0, 19) == 0) ? CMD_CLEAR : CMD_STEP,
                    pick_value(), pick_value());
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_STEP;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // gains still at reset value
        send_sample(CMD_STEP, DATA_MAX, DATA_MIN);
        send_sample(CMD_STEP, DATA_MIN, DATA_MAX);
        wait_drained();

        // positional with integral clamp, rounding of small negatives, clear
        load_settings(16'h0100, 16'h0040, 16'h0180, MODE_POSITIONAL, LIM_W'(100000), '0);
        repeat (3) send_sample(CMD_STEP, DATA_MAX, DATA_MIN);
        repeat (2) send_sample(CMD_STEP, DATA_MIN, DATA_MAX);
        send_sample(CMD_STEP, 16'sd0, 16'sd0);
        send_sample(CMD_STEP, -16'sd1, 16'sd0);
        send_sample(CMD_STEP, 16'sd5, 16'sd0);
        send_sample(CMD_CLEAR, 16'sd1234, -16'sd99);
        send_sample(CMD_STEP, 16'sd100, -16'sd3);
        wait_drained();

        // incremental, full gains, drive clamped to +-1
        load_settings('1, '1, '1, MODE_INCREMENTAL, '1, LIM_W'(1));
        send_sample(CMD_STEP, DATA_MAX, DATA_MIN);
        send_sample(CMD_STEP, DATA_MIN, DATA_MAX);
        send_sample(CMD_STEP, DATA_MAX, DATA_MIN);
        send_sample(CMD_CLEAR, 16'sd0, 16'sd0);
        send_sample(CMD_STEP, 16'sd1, 16'sd0);
        wait_drained();

        load_settings(16'h0001, 16'h0001, 16'h0001, MODE_INCREMENTAL, '0, '1);
        send_sample(CMD_STEP, DATA_MIN, DATA_MAX);
        send_sample(CMD_STEP, DATA_MAX, DATA_MIN);
        send_sample(CMD_STEP, 16'sd0, 16'sd0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_drained();
            load_settings(pick_gain(), pick_gain(), pick_gain(), 1'($urandom_range(0, 1)),
                          pick_limit(), pick_limit());
            if (ph == RANDOM_PHASES / 2) begin
                // keep offering beats while the output side is held off
                hold_off_req = 1'b1;
                no_gaps      = 1'b1;
                repeat (20) send_random();
                no_gaps      = 1'b0;
            end
            repeat (PHASE_SAMPLES) send_random();
        end

        // wind the integral up until the drive saturates positive
        wait_drained();
        load_settings('0, '1, '0, MODE_POSITIONAL, '0, '0);
        no_gaps = 1'b1;
        send_sample(CMD_CLEAR, 16'sd0, 16'sd0);
        repeat (WINDUP_SAMPLES) send_sample(CMD_STEP, DATA_MAX, DATA_MIN);
        wait_drained();

        // negative saturation, then the full-range clamps trim the minimum
        write_reg(CFG_INTEGRAL_LIMIT, '1);
        write_reg(CFG_OUTPUT_LIMIT, '1);
        send_sample(CMD_CLEAR, 16'sd0, 16'sd0);
        repeat (WINDUP_SAMPLES) send_sample(CMD_STEP, DATA_MIN, DATA_MAX);
        no_gaps = 1'b0;
        wait_drained();

        $display("Run: %0d sample beats (%0d clears) under %0d register settings,",
                 n_samples, n_clears, n_settings);
        $display("both loop forms, limit clamps and wind-up saturation; %0d drive beats checked.",
                 drive_count);
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

[files.f]
design/pci_pkg.sv
design/pci_front.sv
design/pci_queue.sv
design/pci_back.sv
design/pid_controller_pos_inc_top.sv
design/pci_checker.sv
tb/pid_drive_checker.sv
tb/tb_top.sv
